// ----- sv/vlr_pkg.sv -----
// ----------------------------------------------------------------------------
// vlr_pkg
// shared widths, limits, types and the control/status bundles of the
// voxel line rasteriser
// ----------------------------------------------------------------------------
package vlr_pkg;

	localparam int COORD_W    = 26;
	localparam int DELTA_W    = COORD_W + 1;
	localparam int KIND_W     = 8;
	localparam int NUM_AXES   = 3;
	localparam int MAX_SPAN   = 63;
	localparam int RES_CAP    = 63;
	localparam int SPAN_LIMIT = (MAX_SPAN < RES_CAP) ? MAX_SPAN : RES_CAP;
	localparam int CNT_W      = $clog2(SPAN_LIMIT + 1);
	localparam int REM_W      = CNT_W + 1;
	localparam int TWOD_W     = REM_W + 1;
	localparam int SUM_W      = REM_W + 2;

	localparam int IN_BITS    = 2 * NUM_AXES * COORD_W + KIND_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = NUM_AXES * COORD_W + KIND_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [COORD_W-1:0]        mag_t;
	typedef logic [KIND_W-1:0]         kind_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [REM_W-1:0]          rem_t;
	typedef logic signed [TWOD_W-1:0]  twod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic load;
		logic diff;
		logic mag;
		logic pick;
		logic init;
		logic step;
		logic flag;
	} vlr_cmd_t;

	typedef struct packed {
		logic span_zero;
		logic span_long;
		logic last_step;
		logic out_free;
	} vlr_status_t;

endpackage

// ----- sv/vlr_datapath.sv -----
// ----------------------------------------------------------------------------
// vlr_datapath
// segment registers, delta and magnitude stages, dominant axis pick and the
// per-axis stepping with exact rounding remainders, plus the output register
// ----------------------------------------------------------------------------
module vlr_datapath
	import vlr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  vlr_cmd_t              cmd,
	output vlr_status_t           status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last,
	output logic                  out_user
);

	coord_t start_q [NUM_AXES];
	coord_t end_q   [NUM_AXES];
	kind_t  kind_q;
	delta_t delta_q [NUM_AXES];
	mag_t   mag_q   [NUM_AXES];
	logic   neg_q   [NUM_AXES];
	axis_t  major_q;
	cnt_t   span_q;
	cnt_t   cnt_q;
	rem_t   twospan_q;
	logic   zero_q;
	logic   long_q;
	logic   dir_q;
	coord_t pos_q   [NUM_AXES];
	twod_t  twod_q  [NUM_AXES];
	rem_t   rem_q   [NUM_AXES];

	coord_t pos_out_q [NUM_AXES];
	kind_t  kind_out_q;
	logic   last_q;
	logic   user_q;
	logic   valid_q;

	coord_t in_start [NUM_AXES];
	coord_t in_end   [NUM_AXES];
	delta_t mag_full [NUM_AXES];
	mag_t   span_full;
	coord_t nxt_pos  [NUM_AXES];
	rem_t   nxt_rem  [NUM_AXES];
	sum_t   acc      [NUM_AXES];
	sum_t   twospan_s;
	axis_t  major_pick;
	logic   gt10, gt20, gt21;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			in_start[a] = in_data[a*COORD_W +: COORD_W];
			in_end[a]   = in_data[(a+NUM_AXES)*COORD_W +: COORD_W];
			mag_full[a] = delta_q[a][DELTA_W-1] ? -delta_q[a] : delta_q[a];
		end
	end

	always_comb begin
		gt10 = mag_q[1] > mag_q[0];
		gt20 = mag_q[2] > mag_q[0];
		gt21 = mag_q[2] > mag_q[1];
		if (gt10) begin
			major_pick = gt21 ? AXIS_Z : AXIS_Y;
		end else begin
			major_pick = gt20 ? AXIS_Z : AXIS_X;
		end
	end

	always_comb begin
		case (major_q)
			AXIS_X:  span_full = mag_q[0];
			AXIS_Y:  span_full = mag_q[1];
			AXIS_Z:  span_full = mag_q[2];
			default: span_full = mag_q[0];
		endcase
	end

	// rounding remainder stays in [0, 2*span); the minor step is at most one
	always_comb begin
		twospan_s = sum_t'({2'b00, twospan_q});
		for (int a = 0; a < NUM_AXES; a++) begin
			acc[a] = sum_t'({2'b00, rem_q[a]}) + sum_t'(twod_q[a]);
			if (major_q == axis_t'(a)) begin
				nxt_pos[a] = dir_q ? pos_q[a] - coord_t'(1) : pos_q[a] + coord_t'(1);
				nxt_rem[a] = rem_q[a];
			end else if (acc[a] >= twospan_s) begin
				nxt_pos[a] = pos_q[a] + coord_t'(1);
				nxt_rem[a] = rem_t'(acc[a] - twospan_s);
			end else if (acc[a] < 0) begin
				nxt_pos[a] = pos_q[a] - coord_t'(1);
				nxt_rem[a] = rem_t'(acc[a] + twospan_s);
			end else begin
				nxt_pos[a] = pos_q[a];
				nxt_rem[a] = rem_t'(acc[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				start_q[a] <= in_start[a];
				end_q[a]   <= in_end[a];
			end
			kind_q <= in_data[2*NUM_AXES*COORD_W +: KIND_W];
		end
		if (cmd.diff) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				delta_q[a] <= delta_t'(end_q[a]) - delta_t'(start_q[a]);
			end
		end
		if (cmd.mag) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				neg_q[a] <= delta_q[a][DELTA_W-1];
				mag_q[a] <= mag_full[a][COORD_W-1:0];
			end
		end
		if (cmd.pick) begin
			major_q <= major_pick;
		end
		if (cmd.init) begin
			zero_q    <= span_full == '0;
			long_q    <= span_full > mag_t'(SPAN_LIMIT);
			span_q    <= span_full[CNT_W-1:0];
			twospan_q <= {span_full[CNT_W-1:0], 1'b0};
			cnt_q     <= '0;
			case (major_q)
				AXIS_X:  dir_q <= neg_q[0];
				AXIS_Y:  dir_q <= neg_q[1];
				AXIS_Z:  dir_q <= neg_q[2];
				default: dir_q <= neg_q[0];
			endcase
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_q[a]  <= start_q[a];
				twod_q[a] <= {delta_q[a][REM_W-1:0], 1'b0};
				rem_q[a]  <= {1'b0, span_full[CNT_W-1:0]};
			end
		end
		if (cmd.step) begin
			cnt_q <= cnt_q + cnt_t'(1);
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_q[a] <= nxt_pos[a];
				rem_q[a] <= nxt_rem[a];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_out_q[a] <= pos_q[a];
			end
			kind_out_q <= kind_q;
			last_q     <= cnt_q == span_q;
			user_q     <= 1'b0;
		end else if (cmd.flag) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_out_q[a] <= start_q[a];
			end
			kind_out_q <= kind_q;
			last_q     <= 1'b1;
			user_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.step || cmd.flag) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign status.span_zero = zero_q;
	assign status.span_long = long_q;
	assign status.last_step = cnt_q == span_q;
	assign status.out_free  = !valid_q || out_ready;

	assign out_valid = valid_q;
	assign out_last  = last_q;
	assign out_user  = user_q;
	assign out_data  = {{OUT_PAD_W{1'b0}}, kind_out_q, pos_out_q[2], pos_out_q[1], pos_out_q[0]};

endmodule

// ----- sv/vlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vlr_ctrl
// sequencer for one segment: set-up steps, then one voxel per free output
// slot, or one flagged transfer for an over-long span, or none for zero span
// ----------------------------------------------------------------------------
module vlr_ctrl
	import vlr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  vlr_status_t status,
	output vlr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MAG,
		ST_PICK,
		ST_INIT,
		ST_BRANCH,
		ST_FLAG,
		ST_RUN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF:  state_q <= ST_MAG;
				ST_MAG:   state_q <= ST_PICK;
				ST_PICK:  state_q <= ST_INIT;
				ST_INIT:  state_q <= ST_BRANCH;
				ST_BRANCH: begin
					if (status.span_zero) begin
						state_q <= ST_IDLE;
					end else if (status.span_long) begin
						state_q <= ST_FLAG;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_FLAG: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (status.out_free && status.last_step) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.diff = state_q == ST_DIFF;
		cmd.mag  = state_q == ST_MAG;
		cmd.pick = state_q == ST_PICK;
		cmd.init = state_q == ST_INIT;
		cmd.step = (state_q == ST_RUN) && status.out_free;
		cmd.flag = (state_q == ST_FLAG) && status.out_free;
	end

endmodule

// ----- sv/voxel_line_rasterizer_3d.sv -----
// ----------------------------------------------------------------------------
// voxel_line_rasterizer_3d
// walks a 3d segment and streams out every voxel on it
// ----------------------------------------------------------------------------
// A segment is taken in one transfer and passes five set-up steps (deltas,
// magnitudes, dominant axis pick, stepper load, branch), then the stepper puts
// one voxel per cycle into the output register while that register is free,
// span+1 voxels for a dominant span of up to 63. The minor axes use exact
// round-half-up stepping. Equal endpoints produce no transfer; a span above
// the limit produces one transfer at the start point with tuser set and tlast
// set. A new segment is accepted as soon as the last voxel of the previous
// one has entered the output register.
module voxel_line_rasterizer_3d
	import vlr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, block_kind, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pos_x, pos_y, pos_z, kind_out, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	// too_long
	output logic                  m_axis_tuser
);

	vlr_cmd_t    cmd;
	vlr_status_t status;

	vlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	vlr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

endmodule

// ----- sv/vlr_checker.sv -----
// ----------------------------------------------------------------------------
// vlr_checker
// port-level checks of the voxel line rasteriser, bound to the top level
// ----------------------------------------------------------------------------
module vlr_checker
	import vlr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  m_axis_tuser
);

	// one segment at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a segment transfer");

	// an over-long span is a single flagged transfer
	a_flag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("flagged result without tlast");

	// no new segment while voxels of the current one are still due
	a_no_accept_mid_segment: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while a segment is still being drawn");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

endmodule

bind voxel_line_rasterizer_3d vlr_checker u_vlr_checker (.*);

// ----- dv/tb_voxel_line_rasterizer_3d.sv -----
// ----------------------------------------------------------------------------
// tb_voxel_line_rasterizer_3d
// self-checking bench for the 3d voxel line rasteriser
// ----------------------------------------------------------------------------
// Segments go in on the slave stream: first a table of hand-picked segments,
// then random ones. Most random segments are short, well-formed lines. The rest
// are equal endpoints, longer spans up to the limit, spans on either side of
// the limit, and fully random endpoints. A line tracer in the bench works out
// every voxel of each accepted segment, and each output transfer is checked
// against the oldest voxel still pending. Table rows whose outcome is obvious
// carry it by hand: no voxel for equal endpoints, and one flagged voxel at the
// start point for an over-long span. Both streams idle and stall at random.
// Once, the output is held off for a long stretch while segments keep coming,
// and twice the input waits for every pending voxel to drain.
module tb_voxel_line_rasterizer_3d;
	import vlr_pkg::*;

	localparam int CMAX           = 33554431;
	localparam int CMIN           = -33554432;
	localparam int PLAN_ROWS      = 22;
	localparam int RANDOM_ITEMS   = 108;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_EMPTY,
		CHECK_FLAGGED
	} check_t;

	typedef struct packed {
		logic [IN_DATA_W-IN_BITS-1:0] pad;
		kind_t                        kind;
		coord_t                       end_z;
		coord_t                       end_y;
		coord_t                       end_x;
		coord_t                       start_z;
		coord_t                       start_y;
		coord_t                       start_x;
	} segment_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		kind_t                kind;
		coord_t               z;
		coord_t               y;
		coord_t               x;
	} voxel_data_t;

	typedef struct {
		voxel_data_t data;
		logic        last;
		logic        too_long;
	} voxel_t;

	typedef struct packed {
		check_t   mode;
		segment_t seg;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// start_x, start_y, start_z, end_x, end_y, end_z, block_kind, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// pos_x, pos_y, pos_z, kind_out, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	// too_long
	logic                  m_axis_tuser;

	voxel_t voxel_q [$];
	int     faults = 0;
	int     idle_cycles = 0;
	bit     hold_req = 1'b0;

	voxel_line_rasterizer_3d u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// round(num / den) with ties upward, den positive
	function automatic longint round_ratio(input longint num, input longint den);
		longint n;
		longint q;
		n = 2 * num + den;
		q = n / (2 * den);
		if ((n % (2 * den)) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic void trace_segment(input segment_t seg);
		longint s [NUM_AXES];
		longint d [NUM_AXES];
		longint p [NUM_AXES];
		longint span;
		longint dir;
		axis_t  major;
		axis_t  ma;
		axis_t  mb;
		voxel_t v;
		s[AXIS_X] = $signed(seg.start_x);
		s[AXIS_Y] = $signed(seg.start_y);
		s[AXIS_Z] = $signed(seg.start_z);
		d[AXIS_X] = longint'($signed(seg.end_x)) - s[AXIS_X];
		d[AXIS_Y] = longint'($signed(seg.end_y)) - s[AXIS_Y];
		d[AXIS_Z] = longint'($signed(seg.end_z)) - s[AXIS_Z];
		major = AXIS_X;
		if (magnitude(d[AXIS_Y]) > magnitude(d[major]))
			major = AXIS_Y;
		if (magnitude(d[AXIS_Z]) > magnitude(d[major]))
			major = AXIS_Z;
		if (d[major] == 0)
			return;
		v.data = '0;
		v.data.kind = seg.kind;
		span = magnitude(d[major]);
		if (span > SPAN_LIMIT) begin
			v.data.x = seg.start_x;
			v.data.y = seg.start_y;
			v.data.z = seg.start_z;
			v.last = 1'b1;
			v.too_long = 1'b1;
			voxel_q.push_back(v);
			return;
		end
		dir = (d[major] > 0) ? 1 : -1;
		ma = (major == AXIS_X) ? AXIS_Y : AXIS_X;
		mb = (major == AXIS_Z) ? AXIS_Y : AXIS_Z;
		for (longint i = 0; i <= span; i++) begin
			p[major] = s[major] + dir * i;
			p[ma] = s[ma] + round_ratio(i * d[ma], span);
			p[mb] = s[mb] + round_ratio(i * d[mb], span);
			v.data.x = p[AXIS_X][COORD_W-1:0];
			v.data.y = p[AXIS_Y][COORD_W-1:0];
			v.data.z = p[AXIS_Z][COORD_W-1:0];
			v.last = (i == span);
			v.too_long = 1'b0;
			voxel_q.push_back(v);
		end
	endfunction

	function automatic plan_row_t plan_row(input int sx, input int sy, input int sz,
		input int ex, input int ey, input int ez, input int kind, input check_t mode);
		plan_row_t r;
		r = '0;
		r.mode = mode;
		r.seg.start_x = sx[COORD_W-1:0];
		r.seg.start_y = sy[COORD_W-1:0];
		r.seg.start_z = sz[COORD_W-1:0];
		r.seg.end_x = ex[COORD_W-1:0];
		r.seg.end_y = ey[COORD_W-1:0];
		r.seg.end_z = ez[COORD_W-1:0];
		r.seg.kind = kind[KIND_W-1:0];
		return r;
	endfunction

	// move by d, or by -d where that would leave the coordinate range
	function automatic coord_t step_within(input coord_t c, input int d);
		longint t;
		t = longint'(c) + d;
		if (t > CMAX || t < CMIN)
			t = longint'(c) - d;
		return t[COORD_W-1:0];
	endfunction

	function automatic segment_t random_segment();
		segment_t seg;
		coord_t   s [NUM_AXES];
		coord_t   e [NUM_AXES];
		int       d [NUM_AXES];
		int       pick;
		int       span;
		int       major;
		seg = '0;
		for (int a = 0; a < NUM_AXES; a++)
			s[a] = coord_t'($urandom);
		pick = $urandom_range(99);
		major = $urandom_range(NUM_AXES - 1);
		for (int a = 0; a < NUM_AXES; a++)
			d[a] = 0;
		if (pick >= 20) begin
			if (pick < 26)
				span = $urandom_range(SPAN_LIMIT - 1, SPAN_LIMIT + 3);
			else if ($urandom_range(9) == 0)
				span = $urandom_range(32, SPAN_LIMIT);
			else
				span = $urandom_range(1, 16);
			for (int a = 0; a < NUM_AXES; a++)
				d[a] = int'($urandom_range(2 * span)) - span;
			d[major] = ($urandom_range(1) != 0) ? span : -span;
		end
		for (int a = 0; a < NUM_AXES; a++)
			e[a] = (pick >= 8 && pick < 20) ? coord_t'($urandom) : step_within(s[a], d[a]);
		seg.start_x = s[0];
		seg.start_y = s[1];
		seg.start_z = s[2];
		seg.end_x = e[0];
		seg.end_y = e[1];
		seg.end_z = e[2];
		seg.kind = kind_t'($urandom_range(255));
		return seg;
	endfunction

	// mostly short, now and then long
	function automatic int pause_len();
		return ($urandom_range(9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
	endfunction

	task automatic offer(input segment_t seg, input check_t mode);
		voxel_t v;
		if ($urandom_range(99) >= 40) begin
			s_axis_tvalid <= 1'b0;
			repeat (pause_len()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seg;
		do @(posedge clk); while (!s_axis_tready);
		case (mode)
			CHECK_MODEL: trace_segment(seg);
			CHECK_FLAGGED: begin
				v.data = '0;
				v.data.x = seg.start_x;
				v.data.y = seg.start_y;
				v.data.z = seg.start_z;
				v.data.kind = seg.kind;
				v.last = 1'b1;
				v.too_long = 1'b1;
				voxel_q.push_back(v);
			end
			default: ;
		endcase
	endtask

	function automatic void check_field(input string name, input longint want,
		input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			faults++;
		end
	endfunction

	always @(posedge clk) begin
		voxel_data_t got;
		voxel_t      want;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				got = voxel_data_t'(m_axis_tdata);
				if (voxel_q.size() == 0) begin
					$error("voxel transfer with nothing pending: x %0d y %0d z %0d",
						got.x, got.y, got.z);
					faults++;
				end else begin
					want = voxel_q.pop_front();
					check_field("pos_x", want.data.x, got.x);
					check_field("pos_y", want.data.y, got.y);
					check_field("pos_z", want.data.z, got.z);
					check_field("kind_out", want.data.kind, got.kind);
					check_field("last", want.last, m_axis_tlast);
					check_field("too_long", want.too_long, m_axis_tuser);
				end
			end
		end
	end

	initial begin
		int len;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(99) < 35) begin
				m_axis_tready <= 1'b0;
				repeat (pause_len()) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("voxel_line_rasterizer_3d regression: fail");
		$finish;
	end

	initial begin
		plan_row_t plan [PLAN_ROWS];
		plan = '{
			plan_row(0, 0, 0, 0, 0, 0, 8'h00, CHECK_EMPTY),
			plan_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 8'hff, CHECK_EMPTY),
			plan_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 8'h01, CHECK_EMPTY),
			plan_row(0, 0, 0, 1, 0, 0, 8'h5a, CHECK_MODEL),
			plan_row(0, 0, 0, 63, 0, 0, 8'ha5, CHECK_MODEL),
			plan_row(0, 0, 0, 64, 0, 0, 8'h3c, CHECK_FLAGGED),
			plan_row(CMIN, 0, 0, CMAX, 0, 0, 8'hff, CHECK_FLAGGED),
			plan_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 8'h00, CHECK_FLAGGED),
			plan_row(5, CMAX, -7, 5, CMIN, -7, 8'h81, CHECK_FLAGGED),
			plan_row(0, 0, CMAX, 0, 0, CMAX - 64, 8'h42, CHECK_FLAGGED),
			plan_row(0, 0, 0, 0, 0, -63, 8'h7e, CHECK_MODEL),
			// half-way minor steps round upward
			plan_row(0, 0, 0, 1, 2, -1, 8'h11, CHECK_MODEL),
			// equal deltas, the earlier axis leads
			plan_row(0, 0, 0, 5, 5, 5, 8'h22, CHECK_MODEL),
			plan_row(0, 0, 0, 1, 7, -7, 8'h33, CHECK_MODEL),
			plan_row(0, 0, 0, -62, 63, -63, 8'h44, CHECK_MODEL),
			plan_row(0, 0, 0, 0, -63, 63, 8'hc3, CHECK_MODEL),
			plan_row(100, 100, 100, 37, 163, 37, 8'h55, CHECK_MODEL),
			plan_row(10, -3, 7, -20, 5, -1, 8'h66, CHECK_MODEL),
			// near the top and bottom of the coordinate range
			plan_row(CMAX - 31, CMAX, CMIN, CMAX, CMAX - 11, CMIN + 32, 8'h77, CHECK_MODEL),
			plan_row(CMIN, CMIN + 63, CMAX, CMIN + 63, CMIN, CMAX - 63, 8'h99, CHECK_MODEL),
			plan_row(0, 0, 0, 3, -8, 2, 8'hfe, CHECK_MODEL),
			plan_row(-1, -1, -1, 0, 0, 0, 8'h80, CHECK_MODEL)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[n])
			offer(plan[n].seg, plan[n].mode);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (voxel_q.size() != 0);
		// output held off while segments keep coming
		hold_req = 1'b1;
		repeat (RANDOM_ITEMS)
			offer(random_segment(), CHECK_MODEL);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (voxel_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0 && voxel_q.size() == 0)
			$display("voxel_line_rasterizer_3d regression: pass");
		else
			$display("voxel_line_rasterizer_3d regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
sv/vlr_pkg.sv
sv/vlr_datapath.sv
sv/vlr_ctrl.sv
sv/voxel_line_rasterizer_3d.sv
sv/vlr_checker.sv
dv/tb_voxel_line_rasterizer_3d.sv
